[sv/smx_pkg.sv]
// Package with shared types, constants and exp table functions for the softmax row normalizer.
`timescale 1ns / 1ps
`default_nettype none
package smx_pkg;

    localparam int LOGIT_W = 16;
    localparam int PROB_W = 16;
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;
    localparam int SUM_W = 21;
    localparam int EXP_W = 16;
    localparam logic [CNT_W-1:0] NUM_CLASSES_RST = 5'd10;
    localparam logic [16:0] EXP_CUTOFF = 17'd4096;

    typedef struct packed {
        logic [LOGIT_W-1:0] row_max;
        logic [CNT_W-1:0] count;
    } row_job_t;

    function automatic logic [16:0] exp_int(input logic [4:0] k);
        logic [16:0] r;
        begin
            case (k)
                5'd0: r = 17'd65536;
                5'd1: r = 17'd24109;
                5'd2: r = 17'd8869;
                5'd3: r = 17'd3263;
                5'd4: r = 17'd1200;
                5'd5: r = 17'd442;
                5'd6: r = 17'd162;
                5'd7: r = 17'd60;
                5'd8: r = 17'd22;
                5'd9: r = 17'd8;
                5'd10: r = 17'd3;
                5'd11: r = 17'd1;
                default: r = 17'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [16:0] exp_hi(input logic [3:0] h);
        logic [16:0] r;
        begin
            case (h)
                4'd0: r = 17'd65536;
                4'd1: r = 17'd61565;
                4'd2: r = 17'd57835;
                4'd3: r = 17'd54331;
                4'd4: r = 17'd51039;
                4'd5: r = 17'd47947;
                4'd6: r = 17'd45042;
                4'd7: r = 17'd42313;
                4'd8: r = 17'd39750;
                4'd9: r = 17'd37341;
                4'd10: r = 17'd35079;
                4'd11: r = 17'd32954;
                4'd12: r = 17'd30957;
                4'd13: r = 17'd29081;
                4'd14: r = 17'd27319;
                default: r = 17'd25664;
            endcase
            return r;
        end
    endfunction

    function automatic logic [16:0] exp_lo(input logic [3:0] l);
        logic [16:0] r;
        begin
            case (l)
                4'd0: r = 17'd65536;
                4'd1: r = 17'd65280;
                4'd2: r = 17'd65026;
                4'd3: r = 17'd64772;
                4'd4: r = 17'd64520;
                4'd5: r = 17'd64268;
                4'd6: r = 17'd64018;
                4'd7: r = 17'd63768;
                4'd8: r = 17'd63520;
                4'd9: r = 17'd63272;
                4'd10: r = 17'd63025;
                4'd11: r = 17'd62780;
                4'd12: r = 17'd62535;
                4'd13: r = 17'd62291;
                4'd14: r = 17'd62048;
                default: r = 17'd61806;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

[sv/softmax_row_normalizer_top.sv]
// Top level of the softmax row normalizer.
// A row of num_classes logits is taken at one per cycle, while full is low, into a row
// buffer; full then stays high until the back end has taken the row and finished its
// exponent pass over it. The back end runs the exp lookup and sum of each class in
// S_EXP and S_MUL2, then divides each class in a bit-serial restoring divider (S_READ,
// S_DIVS, S_DIV, S_OUT) that sets the output rate; results wait in a one-entry register.
`timescale 1ns / 1ps
`default_nettype none
module softmax_row_normalizer_top #(
    parameter int MAX_CLASSES = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [smx_pkg::CNT_W-1:0] cfg_wdata,
    input  wire logic push,
    output logic full,
    input  wire logic [smx_pkg::LOGIT_W-1:0] logit,
    output logic empty,
    input  wire logic pop,
    output logic [smx_pkg::PROB_W-1:0] probability,
    output logic [smx_pkg::IDX_W-1:0] class_index,
    output logic row_last
);
    import smx_pkg::*;

    localparam int AW = (MAX_CLASSES > 16) ? 4 : $clog2(MAX_CLASSES);

    logic [CNT_W-1:0] num_classes_reg;
    logic [LOGIT_W-1:0] logit_mem [0:(1<<AW)-1];
    logic [LOGIT_W-1:0] rd_data_reg;
    logic [AW-1:0] wr_addr, rd_addr;
    logic wr_en;
    logic [LOGIT_W-1:0] wr_data;
    logic job_valid, job_ready;
    logic buf_busy;
    row_job_t job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_classes_reg <= NUM_CLASSES_RST;
        else if (cfg_we)
            num_classes_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            logit_mem[wr_addr] <= wr_data;
        rd_data_reg <= logit_mem[rd_addr];
    end

    smx_front #(.MAX_CLASSES(MAX_CLASSES), .AW(AW)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_n(num_classes_reg),
        .push(push), .logit(logit), .full(full), .job_valid(job_valid),
        .job(job), .job_ready(job_ready), .buf_busy(buf_busy), .wr_addr(wr_addr),
        .wr_en(wr_en), .wr_data(wr_data)
    );

    smx_back #(.AW(AW)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job),
        .job_ready(job_ready), .buf_busy(buf_busy), .rd_addr(rd_addr),
        .rd_data(rd_data_reg), .empty(empty), .pop(pop), .probability(probability),
        .class_index(class_index), .row_last(row_last)
    );

endmodule
`default_nettype wire

[sv/smx_front.sv]
// Front end: collects a row of logits into a buffer and tracks the row maximum.
`timescale 1ns / 1ps
`default_nettype none
module smx_front #(
    parameter int MAX_CLASSES = 16,
    parameter int AW = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [smx_pkg::CNT_W-1:0] cfg_n,
    input  wire logic push,
    input  wire logic [smx_pkg::LOGIT_W-1:0] logit,
    output logic full,
    output logic job_valid,
    output smx_pkg::row_job_t job,
    input  wire logic job_ready,
    input  wire logic buf_busy,
    output logic [AW-1:0] wr_addr,
    output logic wr_en,
    output logic [smx_pkg::LOGIT_W-1:0] wr_data
);
    import smx_pkg::*;

    localparam int CAP = (MAX_CLASSES < 16) ? MAX_CLASSES : 16;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic signed [LOGIT_W-1:0] max_reg, max_next;
    logic job_valid_reg, job_valid_next;
    logic [CNT_W-1:0] limit;
    logic take;

    always_comb
    begin
        if (cfg_n == '0)
            limit = CNT_W'(1);
        else if (cfg_n > CNT_W'(CAP))
            limit = CNT_W'(CAP);
        else
            limit = cfg_n;
    end

    // The buffer belongs to the back end until its exponent pass over the row is done.
    assign full = job_valid_reg || buf_busy;
    assign take = push && !full;
    assign wr_en = take;
    assign wr_addr = fill_reg[AW-1:0];
    assign wr_data = logit;
    assign job_valid = job_valid_reg;
    assign job.row_max = max_reg;
    assign job.count = limit;

    always_comb
    begin
        fill_next = fill_reg;
        max_next = max_reg;
        job_valid_next = job_valid_reg;
        if (job_valid_reg && job_ready)
            job_valid_next = 1'b0;
        if (take)
        begin
            if (fill_reg == '0 || $signed(logit) > max_reg)
                max_next = $signed(logit);
            if (fill_reg + CNT_W'(1) >= limit)
            begin
                fill_next = '0;
                job_valid_next = 1'b1;
            end
            else
                fill_next = fill_reg + CNT_W'(1);
        end
        if (cfg_we)
            fill_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            max_reg <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            max_reg <= max_next;
            job_valid_reg <= job_valid_next;
        end
    end

    a_no_push_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en)
        else $error("Buffer written while the row is held.");
    a_job_holds: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_ready |=> job_valid && $stable(job.row_max))
        else $error("Row job changed while stalled.");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CNT_W'(CAP))
        else $error("Fill count out of range.");

endmodule
`default_nettype wire

[sv/smx_back.sv]
// Back end: exponent pass, summation and one division per class with a one-entry result register.
`timescale 1ns / 1ps
`default_nettype none
module smx_back #(
    parameter int AW = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    input  smx_pkg::row_job_t job,
    output logic job_ready,
    output logic buf_busy,
    output logic [AW-1:0] rd_addr,
    input  wire logic [smx_pkg::LOGIT_W-1:0] rd_data,
    output logic empty,
    input  wire logic pop,
    output logic [smx_pkg::PROB_W-1:0] probability,
    output logic [smx_pkg::IDX_W-1:0] class_index,
    output logic row_last
);
    import smx_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXP  = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_DIVS = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_READ = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next, j_reg, j_next;
    logic signed [LOGIT_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [33:0] p_reg, p_next;
    logic [3:0] l_reg, l_next;
    logic zero_reg, zero_next;
    logic [EXP_W-1:0] exp_mem [0:(1<<AW)-1];
    logic [EXP_W-1:0] exp_rd_reg;
    logic exp_we;
    logic [EXP_W-1:0] exp_wd;
    logic [31:0] rem_reg, rem_next;
    logic [16:0] quo_reg, quo_next;
    logic [4:0] bit_reg, bit_next;
    logic out_valid_reg, out_valid_next;
    logic [PROB_W-1:0] prob_reg, prob_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic last_reg, last_next;
    logic [16:0] u;
    logic [33:0] prod;
    logic [32:0] tr;
    logic din;
    logic [16:0] p1;
    logic [PROB_W-1:0] qsat;

    assign job_ready = (state_reg == S_IDLE);
    assign buf_busy = (state_reg == S_EXP) || (state_reg == S_MUL2);
    assign rd_addr = j_next[AW-1:0];
    assign empty = !out_valid_reg;
    assign probability = prob_reg;
    assign class_index = idx_reg;
    assign row_last = last_reg;
    assign u = 17'(max_reg - $signed(rd_data)) & 17'h0FFFF;
    assign prod = 34'(exp_int(u[12:8])) * 34'(exp_hi(u[7:4]));
    assign p1 = 17'((p_reg + 34'd32768) >> 16);
    assign din = bit_reg[4] & exp_rd_reg[bit_reg[3:0]];
    assign tr = {rem_reg, din} - {12'd0, sum_reg};
    assign qsat = (quo_reg > 17'd65535) ? 16'hFFFF : quo_reg[15:0];

    always_ff @(posedge clk)
    begin
        if (exp_we)
            exp_mem[j_reg[AW-1:0]] <= exp_wd;
        exp_rd_reg <= exp_mem[j_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        j_next = j_reg;
        max_next = max_reg;
        sum_next = sum_reg;
        p_next = p_reg;
        l_next = l_reg;
        zero_next = zero_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        bit_next = bit_reg;
        out_valid_next = out_valid_reg;
        prob_next = prob_reg;
        idx_next = idx_reg;
        last_next = last_reg;
        exp_we = 1'b0;
        exp_wd = '0;
        if (pop && out_valid_reg)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    n_next = job.count;
                    max_next = job.row_max;
                    j_next = '0;
                    sum_next = '0;
                    state_next = S_EXP;
                end
            end
            S_EXP:
            begin
                p_next = prod;
                l_next = u[3:0];
                zero_next = (u > EXP_CUTOFF);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                exp_we = 1'b1;
                if (zero_reg)
                    exp_wd = '0;
                else
                    exp_wd = EXP_W'((((34'(p1) * 34'(exp_lo(l_reg)) + 34'd32768) >> 16)
                        + 34'd1) >> 1);
                sum_next = sum_reg + SUM_W'(exp_wd);
                if (j_reg + CNT_W'(1) >= n_reg)
                begin
                    j_next = '0;
                    state_next = S_READ;
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                    state_next = S_EXP;
                end
            end
            S_READ:
                state_next = S_DIVS;
            S_DIVS:
            begin
                rem_next = '0;
                quo_next = '0;
                bit_next = 5'd31;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // Restoring division of exp << 16 by the sum, one bit a cycle.
                if (tr[32] == 1'b0)
                begin
                    rem_next = tr[31:0];
                    quo_next = {quo_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[30:0], din};
                    quo_next = {quo_reg[15:0], 1'b0};
                end
                if (bit_reg == 5'd0)
                    state_next = S_OUT;
                else
                    bit_next = bit_reg - 5'd1;
            end
            S_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    prob_next = (sum_reg == '0) ? 16'hFFFF : qsat;
                    idx_next = j_reg[IDX_W-1:0];
                    last_next = (j_reg + CNT_W'(1) >= n_reg);
                    if (j_reg + CNT_W'(1) >= n_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        j_next = j_reg + CNT_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            j_reg <= '0;
            n_reg <= CNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            j_reg <= j_next;
            n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg <= max_next;
        sum_reg <= sum_next;
        p_reg <= p_next;
        l_reg <= l_next;
        zero_reg <= zero_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        bit_reg <= bit_next;
        prob_reg <= prob_next;
        idx_reg <= idx_next;
        last_reg <= last_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(prob_reg))
        else $error("Result changed while waiting.");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_ready |-> state_reg == S_IDLE)
        else $error("Job taken while busy.");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && state_next == S_IDLE |-> last_next)
        else $error("Row ended without last flag.");

endmodule
`default_nettype wire
